>>> src/dslt_pkg.sv
// shared types, constants and arithmetic helpers of the dense sigmoid layer trainer
`timescale 1ns / 1ps
package dslt_pkg;

  localparam int BatchRowsDef    = 4;
  localparam int FeatureCountDef = 4;
  localparam int NeuronCountDef  = 4;

  localparam logic [15:0] LearnRateReset = 16'd655;
  localparam int AccW  = 40;
  localparam int ProdW = 57;

  typedef enum logic [2:0] {
    KIND_WEIGHT = 3'd0,
    KIND_BIAS   = 3'd1,
    KIND_FEAT   = 3'd2,
    KIND_TARGET = 3'd3,
    KIND_TRAIN  = 3'd4
  } kind_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_F_INIT,
    OP_F_MAC,
    OP_F_Z,
    OP_F_SIG,
    OP_F_DZ1,
    OP_F_DZ2,
    OP_CLR,
    OP_G_MAC,
    OP_MUL,
    OP_G_UPD,
    OP_B_MAC,
    OP_B_UPD
  } op_e;

  typedef struct packed {
    op_e  op;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic out_hold;
  } sts_t;

  function automatic logic [12:0] sig_tab(input logic [4:0] idx);
    logic [12:0] r;
    case (idx)
      5'd0:    r = 13'd2048;
      5'd1:    r = 13'd2550;
      5'd2:    r = 13'd2994;
      5'd3:    r = 13'd3349;
      5'd4:    r = 13'd3608;
      5'd5:    r = 13'd3785;
      5'd6:    r = 13'd3902;
      5'd7:    r = 13'd3976;
      5'd8:    r = 13'd4022;
      5'd9:    r = 13'd4051;
      5'd10:   r = 13'd4069;
      5'd11:   r = 13'd4079;
      5'd12:   r = 13'd4086;
      5'd13:   r = 13'd4090;
      5'd14:   r = 13'd4092;
      5'd15:   r = 13'd4094;
      default: r = 13'd4095;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [39:0] x);
    logic signed [15:0] r;
    if (x > 40'sd32767) begin
      r = 16'sh7fff;
    end else if (x < -40'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = x[15:0];
    end
    return r;
  endfunction

endpackage

>>> src/dslt_datapath.sv
// stores, shared multiply-accumulate, sigmoid and update arithmetic
`timescale 1ns / 1ps
module dslt_datapath #(
  parameter int BATCH_ROWS    = dslt_pkg::BatchRowsDef,
  parameter int FEATURE_COUNT = dslt_pkg::FeatureCountDef,
  parameter int NEURON_COUNT  = dslt_pkg::NeuronCountDef,
  localparam int RW = (BATCH_ROWS > 1) ? $clog2(BATCH_ROWS) : 1,
  localparam int FW = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1,
  localparam int NW = (NEURON_COUNT > 1) ? $clog2(NEURON_COUNT) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dslt_pkg::cmd_t      cmd_i,
  input  logic [RW-1:0]       row_i,
  input  logic [FW-1:0]       feat_i,
  input  logic [NW-1:0]       neu_i,
  output dslt_pkg::sts_t      sts_o,
  input  logic [2:0]          kind_i,
  input  logic [1:0]          row_index_i,
  input  logic [1:0]          feature_index_i,
  input  logic [1:0]          neuron_index_i,
  input  logic signed [15:0]  value_i,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          out_row_o,
  output logic [1:0]          out_neuron_o,
  output logic [12:0]         activation_o,
  output logic                last_o
);

  localparam int AW = dslt_pkg::AccW;
  localparam int PW = dslt_pkg::ProdW;

  logic signed [15:0] w_q  [FEATURE_COUNT][NEURON_COUNT];
  logic signed [15:0] b_q  [NEURON_COUNT];
  logic signed [15:0] x_q  [BATCH_ROWS][FEATURE_COUNT];
  logic signed [15:0] y_q  [BATCH_ROWS];
  logic signed [15:0] dz_q [BATCH_ROWS][NEURON_COUNT];

  logic [15:0]          rate_q;
  logic signed [AW-1:0] acc_q, acc_d;
  logic signed [PW-1:0] prod_q;
  logic [4:0]           seg_q;
  logic [10:0]          frac_q;
  logic                 neg_q;
  logic [12:0]          a_q;
  logic [25:0]          p_q;
  logic signed [17:0]   d_q;
  logic                 out_valid_q;
  logic [1:0]           out_row_q, out_neu_q;
  logic [12:0]          out_act_q;
  logic                 out_last_q;

  logic signed [15:0] wr, br, xr, yr, dzr, mb;
  logic signed [31:0] mac;
  logic signed [AW-1:0] zr;
  logic signed [15:0] z;
  logic [16:0] mag;
  logic [12:0] tlo, thi, dif, pos, a_new;
  logic [20:0] stp;
  logic signed [44:0] t;
  logic signed [44:0] dzr_full;
  logic signed [PW-1:0] rw_full, rb_full;
  logic signed [15:0] w_new, b_new;
  logic [FW-1:0] lf;
  logic [NW-1:0] ln;
  logic [RW-1:0] lr;
  logic f_ok, n_ok, r_ok;

  assign wr  = w_q[feat_i][neu_i];
  assign br  = b_q[neu_i];
  assign xr  = x_q[row_i][feat_i];
  assign yr  = y_q[row_i];
  assign dzr = dz_q[row_i][neu_i];
  assign mb  = (cmd_i.op == dslt_pkg::OP_G_MAC) ? dzr : wr;
  assign mac = xr * mb;

  always_comb begin
    acc_d = acc_q;
    unique case (cmd_i.op)
      dslt_pkg::OP_F_INIT: acc_d = AW'(br) <<< 12;
      dslt_pkg::OP_F_MAC, dslt_pkg::OP_G_MAC: acc_d = acc_q + AW'(mac);
      dslt_pkg::OP_B_MAC:  acc_d = acc_q + AW'(dzr);
      dslt_pkg::OP_CLR:    acc_d = '0;
      default:             acc_d = acc_q;
    endcase
  end

  assign zr  = (acc_q + AW'(2048)) >>> 12;
  assign z   = dslt_pkg::sat16(zr);
  assign mag = z[15] ? (17'd0 - {z[15], z}) : {1'b0, z};

  assign tlo   = dslt_pkg::sig_tab(seg_q);
  assign thi   = dslt_pkg::sig_tab(seg_q + 5'd1);
  assign dif   = thi - tlo;
  assign stp   = (21'(dif) * 21'(frac_q) + 21'd1024) >> 11;
  assign pos   = seg_q[4] ? 13'd4095 : (tlo + stp[12:0]);
  assign a_new = neg_q ? (13'd4096 - pos) : pos;

  assign t        = d_q * $signed({1'b0, p_q});
  assign dzr_full = (t + 45'sd4194304) >>> 23;

  assign rw_full = (prod_q + (PW'(1) <<< 27)) >>> 28;
  assign rb_full = (prod_q + (PW'(1) <<< 15)) >>> 16;
  assign w_new = dslt_pkg::sat16(40'(wr) - 40'($signed(rw_full[29:0])));
  assign b_new = dslt_pkg::sat16(40'(br) - 40'($signed(rb_full[29:0])));

  assign lf   = FW'(feature_index_i);
  assign ln   = NW'(neuron_index_i);
  assign lr   = RW'(row_index_i);
  assign f_ok = 32'(feature_index_i) < FEATURE_COUNT;
  assign n_ok = 32'(neuron_index_i) < NEURON_COUNT;
  assign r_ok = 32'(row_index_i) < BATCH_ROWS;

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (cmd_i.op == dslt_pkg::OP_LOAD) begin
      case (kind_i)
        dslt_pkg::KIND_WEIGHT: if (f_ok && n_ok) w_q[lf][ln] <= value_i;
        dslt_pkg::KIND_BIAS:   if (n_ok) b_q[ln] <= value_i;
        dslt_pkg::KIND_FEAT:   if (r_ok && f_ok) x_q[lr][lf] <= value_i;
        dslt_pkg::KIND_TARGET: if (r_ok) y_q[lr] <= value_i;
        default: ;
      endcase
    end
    if (cmd_i.op == dslt_pkg::OP_F_Z) begin
      seg_q  <= mag[15:11];
      frac_q <= mag[10:0];
      neg_q  <= z[15];
    end
    if (cmd_i.op == dslt_pkg::OP_F_SIG) begin
      a_q       <= a_new;
      out_row_q <= 2'(row_i);
      out_neu_q <= 2'(neu_i);
      out_act_q <= a_new;
      out_last_q <= cmd_i.last;
    end
    if (cmd_i.op == dslt_pkg::OP_F_DZ1) begin
      p_q <= 26'(a_q) * 26'(13'd4096 - a_q);
      d_q <= $signed({5'b0, a_q}) - 18'(yr);
    end
    if (cmd_i.op == dslt_pkg::OP_F_DZ2) begin
      dz_q[row_i][neu_i] <= dzr_full[15:0];
    end
    if (cmd_i.op == dslt_pkg::OP_MUL) begin
      // gradient sums stay within 33 signed bits
      prod_q <= $signed({1'b0, rate_q}) * $signed(acc_q[32:0]);
    end
    if (cmd_i.op == dslt_pkg::OP_G_UPD) begin
      w_q[feat_i][neu_i] <= w_new;
    end
    if (cmd_i.op == dslt_pkg::OP_B_UPD) begin
      b_q[neu_i] <= b_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q      <= dslt_pkg::LearnRateReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        rate_q <= cfg_wdata_i;
      end
      if (cmd_i.op == dslt_pkg::OP_F_SIG) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.out_hold = out_valid_q & out_stall_i;
  assign out_valid_o  = out_valid_q;
  assign out_row_o    = out_row_q;
  assign out_neuron_o = out_neu_q;
  assign activation_o = out_act_q;
  assign last_o       = out_last_q;

  a_out_from_sig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.op == dslt_pkg::OP_F_SIG))
    else $error("output item raised without a sigmoid step");

endmodule

>>> src/dslt_ctrl.sv
// sequencer for load, forward, gradient and update phases
`timescale 1ns / 1ps
module dslt_ctrl #(
  parameter int BATCH_ROWS    = dslt_pkg::BatchRowsDef,
  parameter int FEATURE_COUNT = dslt_pkg::FeatureCountDef,
  parameter int NEURON_COUNT  = dslt_pkg::NeuronCountDef,
  localparam int RW = (BATCH_ROWS > 1) ? $clog2(BATCH_ROWS) : 1,
  localparam int FW = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1,
  localparam int NW = (NEURON_COUNT > 1) ? $clog2(NEURON_COUNT) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [2:0]      kind_i,
  output logic            in_stall_o,
  input  dslt_pkg::sts_t  sts_i,
  output dslt_pkg::cmd_t  cmd_o,
  output logic [RW-1:0]   row_o,
  output logic [FW-1:0]   feat_o,
  output logic [NW-1:0]   neu_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_F_INIT, ST_F_MAC, ST_F_Z, ST_F_SIG, ST_F_DZ1, ST_F_DZ2,
    ST_G_INIT, ST_G_MAC, ST_G_MUL, ST_G_UPD,
    ST_B_INIT, ST_B_MAC, ST_B_MUL, ST_B_UPD
  } state_e;

  localparam logic [RW-1:0] RowLast  = RW'(BATCH_ROWS - 1);
  localparam logic [FW-1:0] FeatLast = FW'(FEATURE_COUNT - 1);
  localparam logic [NW-1:0] NeuLast  = NW'(NEURON_COUNT - 1);

  state_e        state_q;
  logic [RW-1:0] i_q;
  logic [FW-1:0] k_q;
  logic [NW-1:0] j_q;
  logic          is_load;

  assign is_load = (kind_i == dslt_pkg::KIND_WEIGHT) || (kind_i == dslt_pkg::KIND_BIAS) ||
                   (kind_i == dslt_pkg::KIND_FEAT) || (kind_i == dslt_pkg::KIND_TARGET);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          i_q <= '0;
          j_q <= '0;
          k_q <= '0;
          if (in_valid_i && kind_i == dslt_pkg::KIND_TRAIN) state_q <= ST_F_INIT;
        end
        ST_F_INIT: begin
          k_q     <= '0;
          state_q <= ST_F_MAC;
        end
        ST_F_MAC: begin
          if (k_q == FeatLast) begin
            state_q <= ST_F_Z;
          end else begin
            k_q <= k_q + 1'b1;
          end
        end
        ST_F_Z: state_q <= ST_F_SIG;
        ST_F_SIG: if (!sts_i.out_hold) state_q <= ST_F_DZ1;
        ST_F_DZ1: state_q <= ST_F_DZ2;
        ST_F_DZ2: begin
          if (j_q == NeuLast) begin
            j_q <= '0;
            if (i_q == RowLast) begin
              i_q     <= '0;
              k_q     <= '0;
              state_q <= ST_G_INIT;
            end else begin
              i_q     <= i_q + 1'b1;
              state_q <= ST_F_INIT;
            end
          end else begin
            j_q     <= j_q + 1'b1;
            state_q <= ST_F_INIT;
          end
        end
        ST_G_INIT: begin
          i_q     <= '0;
          state_q <= ST_G_MAC;
        end
        ST_G_MAC: begin
          if (i_q == RowLast) begin
            state_q <= ST_G_MUL;
          end else begin
            i_q <= i_q + 1'b1;
          end
        end
        ST_G_MUL: state_q <= ST_G_UPD;
        ST_G_UPD: begin
          if (j_q == NeuLast) begin
            j_q <= '0;
            if (k_q == FeatLast) begin
              k_q     <= '0;
              state_q <= ST_B_INIT;
            end else begin
              k_q     <= k_q + 1'b1;
              state_q <= ST_G_INIT;
            end
          end else begin
            j_q     <= j_q + 1'b1;
            state_q <= ST_G_INIT;
          end
        end
        ST_B_INIT: begin
          i_q     <= '0;
          state_q <= ST_B_MAC;
        end
        ST_B_MAC: begin
          if (i_q == RowLast) begin
            state_q <= ST_B_MUL;
          end else begin
            i_q <= i_q + 1'b1;
          end
        end
        ST_B_MUL: state_q <= ST_B_UPD;
        ST_B_UPD: begin
          if (j_q == NeuLast) begin
            j_q     <= '0;
            state_q <= ST_IDLE;
          end else begin
            j_q     <= j_q + 1'b1;
            state_q <= ST_B_INIT;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o.last = (i_q == RowLast) && (j_q == NeuLast);
    unique case (state_q)
      ST_IDLE:   cmd_o.op = (in_valid_i && is_load) ? dslt_pkg::OP_LOAD : dslt_pkg::OP_NOP;
      ST_F_INIT: cmd_o.op = dslt_pkg::OP_F_INIT;
      ST_F_MAC:  cmd_o.op = dslt_pkg::OP_F_MAC;
      ST_F_Z:    cmd_o.op = dslt_pkg::OP_F_Z;
      ST_F_SIG:  cmd_o.op = sts_i.out_hold ? dslt_pkg::OP_NOP : dslt_pkg::OP_F_SIG;
      ST_F_DZ1:  cmd_o.op = dslt_pkg::OP_F_DZ1;
      ST_F_DZ2:  cmd_o.op = dslt_pkg::OP_F_DZ2;
      ST_G_INIT, ST_B_INIT: cmd_o.op = dslt_pkg::OP_CLR;
      ST_G_MAC:  cmd_o.op = dslt_pkg::OP_G_MAC;
      ST_G_MUL, ST_B_MUL: cmd_o.op = dslt_pkg::OP_MUL;
      ST_G_UPD:  cmd_o.op = dslt_pkg::OP_G_UPD;
      ST_B_MAC:  cmd_o.op = dslt_pkg::OP_B_MAC;
      ST_B_UPD:  cmd_o.op = dslt_pkg::OP_B_UPD;
      default:   cmd_o.op = dslt_pkg::OP_NOP;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign row_o  = i_q;
  assign feat_o = k_q;
  assign neu_o  = j_q;

  a_sig_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_F_SIG && sts_i.out_hold) |=> (state_q == ST_F_SIG))
    else $error("sigmoid step left while output item still held");

  a_bias_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_B_UPD && j_q == NeuLast) |=> (state_q == ST_IDLE))
    else $error("train step did not finish after last bias update");

  a_feat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_F_MAC || state_q == ST_G_UPD) |-> (k_q <= FeatLast))
    else $error("feature counter out of range");

endmodule

>>> src/dense_sigmoid_layer_trainer_core.sv
// top level of the dense sigmoid layer trainer
`timescale 1ns / 1ps
// One fully connected sigmoid layer trained by mean-squared-error gradient descent.
// Load items (weight, bias, feature, target) are accepted while the block is idle. A
// train item is accepted and then occupies the block for the forward pass and
// gradient, then the weight update and the bias update, all run in turn on the
// single shared multiply-accumulate unit; a held output item stalls the sequence.
// Activations leave row-major, last set on the final one.
module dense_sigmoid_layer_trainer_core #(
  parameter int BATCH_ROWS    = dslt_pkg::BatchRowsDef,
  parameter int FEATURE_COUNT = dslt_pkg::FeatureCountDef,
  parameter int NEURON_COUNT  = dslt_pkg::NeuronCountDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         kind_i,
  input  logic [1:0]         row_index_i,
  input  logic [1:0]         feature_index_i,
  input  logic [1:0]         neuron_index_i,
  input  logic signed [15:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         out_row_o,
  output logic [1:0]         out_neuron_o,
  output logic [12:0]        activation_o,
  output logic               last_o
);

  localparam int RW = (BATCH_ROWS > 1) ? $clog2(BATCH_ROWS) : 1;
  localparam int FW = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
  localparam int NW = (NEURON_COUNT > 1) ? $clog2(NEURON_COUNT) : 1;

  dslt_pkg::cmd_t cmd;
  dslt_pkg::sts_t sts;
  logic [RW-1:0]  row;
  logic [FW-1:0]  feat;
  logic [NW-1:0]  neu;

  dslt_ctrl #(
    .BATCH_ROWS(BATCH_ROWS), .FEATURE_COUNT(FEATURE_COUNT), .NEURON_COUNT(NEURON_COUNT)
  ) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .kind_i, .in_stall_o,
    .sts_i(sts), .cmd_o(cmd), .row_o(row), .feat_o(feat), .neu_o(neu)
  );

  dslt_datapath #(
    .BATCH_ROWS(BATCH_ROWS), .FEATURE_COUNT(FEATURE_COUNT), .NEURON_COUNT(NEURON_COUNT)
  ) u_datapath (
    .clk_i, .rst_ni, .cmd_i(cmd), .row_i(row), .feat_i(feat), .neu_i(neu),
    .sts_o(sts), .kind_i, .row_index_i, .feature_index_i, .neuron_index_i, .value_i,
    .cfg_we_i, .cfg_wdata_i, .out_valid_o, .out_stall_i, .out_row_o, .out_neuron_o,
    .activation_o, .last_o
  );

endmodule

>>> sim/testbench.sv
// testbench of the dense sigmoid layer trainer: model-based checking of activation items
`timescale 1ns / 1ps
module testbench;

  typedef struct {
    logic [1:0]  row;
    logic [1:0]  neuron;
    logic [12:0] act;
    logic        last;
  } act_item_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [15:0]        cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [2:0]         kind_i = '0;
  logic [1:0]         row_index_i = '0;
  logic [1:0]         feature_index_i = '0;
  logic [1:0]         neuron_index_i = '0;
  logic signed [15:0] value_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         out_row_o;
  logic [1:0]         out_neuron_o;
  logic [12:0]        activation_o;
  logic               last_o;

  dense_sigmoid_layer_trainer_core DUT (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predicted layer state
  longint    wgt [4][4];
  longint    bias [4];
  longint    feat [4][4];
  longint    tgt [4];
  longint    rate;
  act_item_t act_queue [$];
  int        errors = 0;
  bit        quiet = 0;
  bit        hold_off = 0;

  function automatic longint rnd_shift(longint x, int s);
    return (x + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clamp16(longint x);
    if (x > 32767) return 32767;
    if (x < -32768) return -32768;
    return x;
  endfunction

  function automatic longint sig_approx(longint z);
    longint mag, pos, seg, d;
    mag = z < 0 ? -z : z;
    seg = mag >> 11;
    if (seg >= 16) begin
      pos = dslt_pkg::sig_tab(5'd16);
    end else begin
      d = longint'(dslt_pkg::sig_tab(5'(seg + 1))) - longint'(dslt_pkg::sig_tab(5'(seg)));
      pos = longint'(dslt_pkg::sig_tab(5'(seg))) + ((d * (mag & 2047) + 1024) >> 11);
    end
    return z < 0 ? 4096 - pos : pos;
  endfunction

  task automatic predict_train();
    longint a [4][4];
    longint dz [4][4];
    longint acc;
    act_item_t it;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        acc = bias[j] * 4096;
        for (int k = 0; k < 4; k++) acc += feat[i][k] * wgt[k][j];
        a[i][j] = sig_approx(clamp16(rnd_shift(acc, 12)));
        it.row = 2'(i);
        it.neuron = 2'(j);
        it.act = 13'(a[i][j]);
        it.last = (i == 3 && j == 3);
        act_queue.push_back(it);
        dz[i][j] = rnd_shift(2 * (a[i][j] - tgt[i]) * (a[i][j] * (4096 - a[i][j])), 24);
      end
    end
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j < 4; j++) begin
        acc = 0;
        for (int i = 0; i < 4; i++) acc += feat[i][k] * dz[i][j];
        wgt[k][j] = clamp16(wgt[k][j] - rnd_shift(rate * acc, 28));
      end
    end
    for (int j = 0; j < 4; j++) begin
      acc = 0;
      for (int i = 0; i < 4; i++) acc += dz[i][j];
      bias[j] = clamp16(bias[j] - rnd_shift(rate * acc, 16));
    end
  endtask

  task automatic send_item(logic [2:0] kind, logic [1:0] r, logic [1:0] f,
                           logic [1:0] n, logic [15:0] v);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    row_index_i <= r;
    feature_index_i <= f;
    neuron_index_i <= n;
    value_i <= v;
    do @(posedge clk_i); while (in_stall_o);
    case (kind)
      dslt_pkg::KIND_WEIGHT: wgt[f][n] = longint'(signed'(v));
      dslt_pkg::KIND_BIAS:   bias[n] = longint'(signed'(v));
      dslt_pkg::KIND_FEAT:   feat[r][f] = longint'(signed'(v));
      dslt_pkg::KIND_TARGET: tgt[r] = longint'(signed'(v));
      dslt_pkg::KIND_TRAIN:  predict_train();
      default: ;
    endcase
  endtask

  task automatic stop_input();
    in_valid_i <= 1'b0;
  endtask

  task automatic write_rate(logic [15:0] v);
    stop_input();
    wait (act_queue.size() == 0);
    repeat (300) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    rate = v;
  endtask

  task automatic load_all(bit extreme);
    logic [15:0] v;
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j < 4; j++) begin
        v = extreme ? ((k + j) % 2 ? 16'h8000 : 16'h7fff) : 16'($urandom_range(0, 8191) - 4096);
        send_item(dslt_pkg::KIND_WEIGHT, 2'($urandom), 2'(k), 2'(j), v);
        v = extreme ? (j % 2 ? 16'h7fff : 16'h8000) : 16'($urandom_range(0, 8191) - 4096);
        send_item(dslt_pkg::KIND_FEAT, 2'(j), 2'(k), 2'($urandom), v);
      end
      send_item(dslt_pkg::KIND_BIAS, 2'($urandom), 2'($urandom), 2'(k),
                extreme ? 16'h8000 : 16'($urandom));
      send_item(dslt_pkg::KIND_TARGET, 2'(k), 2'($urandom), 2'($urandom),
                extreme ? 16'h7fff : 16'($urandom_range(0, 4096)));
    end
  endtask

  task automatic test_directed();
    load_all(1);
    send_item(dslt_pkg::KIND_TRAIN, 2'd0, 2'd0, 2'd0, 16'd0);
    send_item(3'd5, 2'd3, 2'd3, 2'd3, 16'hffff);
    send_item(3'd7, 2'd0, 2'd0, 2'd0, 16'h5555);
    send_item(dslt_pkg::KIND_TRAIN, 2'd3, 2'd3, 2'd3, 16'hffff);
  endtask

  task automatic test_rates();
    write_rate(16'hffff);
    send_item(dslt_pkg::KIND_TRAIN, 2'd0, 2'd0, 2'd0, 16'd0);
    write_rate(16'd0);
    send_item(dslt_pkg::KIND_TRAIN, 2'd0, 2'd0, 2'd0, 16'd0);
    write_rate(16'd4000);
  endtask

  task automatic test_random();
    load_all(0);
    for (int i = 0; i < 160; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: send_item(dslt_pkg::KIND_TRAIN, 2'($urandom), 2'($urandom), 2'($urandom),
                           16'($urandom));
        3:       send_item(3'($urandom_range(5, 7)), 2'($urandom), 2'($urandom),
                           2'($urandom), 16'($urandom));
        default: send_item(3'($urandom_range(0, 3)), 2'($urandom), 2'($urandom),
                           2'($urandom),
                           $urandom_range(0, 1) ? 16'($urandom) :
                           16'($urandom_range(0, 8191) - 4096));
      endcase
    end
  endtask

  task automatic test_backpressure();
    hold_off = 1;
    for (int i = 0; i < 4; i++) send_item(dslt_pkg::KIND_TRAIN, 2'd0, 2'd0, 2'd0, 16'd0);
    wait (!hold_off);
  endtask

  always @(posedge clk_i) begin
    if (hold_off) begin
      out_stall_i <= 1'b1;
    end else if (!quiet) begin
      out_stall_i <= ($urandom_range(0, 4) == 0);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  initial begin
    wait (hold_off);
    repeat (400) @(posedge clk_i);
    hold_off = 0;
  end

  always @(posedge clk_i) begin
    act_item_t exp_item;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (act_queue.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected item: act %0d", activation_o);
      end else begin
        exp_item = act_queue.pop_front();
        if (out_row_o !== exp_item.row || out_neuron_o !== exp_item.neuron ||
            activation_o !== exp_item.act || last_o !== exp_item.last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp r%0d n%0d a%0d l%0d got r%0d n%0d a%0d l%0d",
                     exp_item.row, exp_item.neuron, exp_item.act, exp_item.last,
                     out_row_o, out_neuron_o, activation_o, last_o);
        end
      end
    end
  end

  initial begin
    rate = dslt_pkg::LearnRateReset;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_rates();
    test_random();
    test_backpressure();
    quiet = 1;
    for (int i = 0; i < 10; i++) send_item(dslt_pkg::KIND_TRAIN, 2'd0, 2'd0, 2'd0, 16'd0);
    stop_input();
    wait (act_queue.size() == 0);
    repeat (400) @(posedge clk_i);
    if (errors == 0 && act_queue.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

>>> dense_sigmoid_layer_trainer_core.f
src/dslt_pkg.sv
src/dslt_datapath.sv
src/dslt_ctrl.sv
src/dense_sigmoid_layer_trainer_core.sv
sim/testbench.sv
